@@ hw/rtl/sedsamp_pkg.sv @@
// ----------------------------------------------------------------------------
// sedsamp_pkg
// shared sizes, register indexes and saturation helper for the serpentine
// error diffusion sampler
// ----------------------------------------------------------------------------
package sedsamp_pkg;

  // image geometry limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);

  // field widths
  localparam int DimW    = 11;
  localparam int LevelW  = 24;
  localparam int SineW   = 16;
  localparam int GainW   = 16;
  localparam int ThrW    = 24;
  localparam int CarryW  = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 24;

  // stream payload widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  typedef enum logic [CfgAddrW-1:0] {
    RegImageWidth     = 3'd0,
    RegImageHeight    = 3'd1,
    RegSampleThreshold = 3'd2,
    RegFireLevel      = 3'd3,
    RegSlideGain      = 3'd4
  } cfg_reg_e;

  // clamp a wide signed value into signed 32 bits
  function automatic logic signed [CarryW-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh00_7FFF_FFFF;
    lo = -40'sh00_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[CarryW-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/serpentine_error_diffusion_sampler_core.sv @@
// ----------------------------------------------------------------------------
// serpentine_error_diffusion_sampler_core
// error diffusion sampler over a serpentine pixel stream with a line store
// ----------------------------------------------------------------------------
// flow: an accepted pixel passes S_IMP, S_FIRE, S_MUL and S_WB, its result is
//   registered at write back, and only then is the next pixel accepted, set by the
//   read-modify-write of the line store and the single shared weight multiplier
// reset: counters, carries and registers go to their reset values, then the
//   line store is swept to zero over all 1024 entries with no pixel accepted
// image end: the store is swept again over columns 0 to the widest column used
//   in that image, one entry a cycle, before the next pixel is accepted
module serpentine_error_diffusion_sampler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sedsamp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sedsamp_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sedsamp_pkg::InDataW-1:0] s_axis_tdata,  // pixel_level, row_sine
  // result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sedsamp_pkg::OutDataW-1:0] m_axis_tdata, // pixel_column, pixel_row, zero pad
  output logic                           m_axis_tuser,   // sample_fired
  output logic                           m_axis_tlast    // image_done
);
  import sedsamp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IMP,
    S_FIRE,
    S_MUL,
    S_WB,
    S_CLR
  } state_e;

  state_e state_q;

  // configuration registers
  logic [DimW-1:0]  width_q, height_q;
  logic [ThrW-1:0]  thresh_q, fire_q;
  logic [GainW-1:0] gain_q;

  // position of the next pixel and the widest column touched this image
  logic [ColW-1:0] col_q, max_col_q;
  logic [RowW-1:0] row_q;
  logic [SineW-1:0] wsine_q;

  // carries
  logic signed [CarryW-1:0] fwd_q, diag_q;

  // per pixel working registers
  logic [LevelW-1:0]        level_q;
  logic [SineW-1:0]         sine_q;
  logic [LevelW+SineW-1:0]  prod_q;
  logic [16:0]              g_q;
  logic signed [CarryW-1:0] imp0_q, imp_q;
  logic                     fired_q;
  logic signed [49:0]       m_q;

  // line store sweep
  logic [ColW-1:0] clr_cnt_q, clr_last_q;

  // result register
  logic            out_valid_q, out_fired_q, out_last_q;
  logic [ColW-1:0] out_col_q;
  logic [RowW-1:0] out_row_q;

  // line store, one read port and one write port
  logic [CarryW-1:0] line_mem [MaxWidth];
  logic [CarryW-1:0] rd_q;
  logic              mem_we;
  logic [ColW-1:0]   mem_waddr;
  logic [CarryW-1:0] mem_wdata;

  logic in_go;
  assign in_go         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // input fields
  logic [LevelW-1:0] in_level;
  logic [SineW-1:0]  in_sine;
  assign in_level = s_axis_tdata[LevelW-1:0];
  assign in_sine  = s_axis_tdata[LevelW+SineW-1:LevelW];

  // effective geometry, out of range values clamped
  logic [DimW-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = DimW'(1);
    else if (width_q > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
    h_eff = height_q;
    if (height_q == '0) h_eff = DimW'(1);
    else if (height_q > DimW'(MaxHeight)) h_eff = DimW'(MaxHeight);
  end

  // row end and image end for the pixel in flight
  logic odd_row, row_end, img_last;
  assign odd_row  = row_q[0];
  assign row_end  = odd_row ? (col_q == '0) : (DimW'(col_q) >= (w_eff - DimW'(1)));
  assign img_last = row_end && ((DimW'(row_q) + DimW'(1)) >= h_eff);

  // weight sine is latched at the first pixel of each even row
  logic [SineW-1:0] wsine_d;
  assign wsine_d = (!odd_row && (col_q == '0)) ? in_sine : wsine_q;

  // importance: rounded sine times level plus both carries
  logic [LevelW+SineW:0] p_round;
  logic [25:0]           p_val;
  logic signed [39:0]    imp_sum;
  logic [31:0]           g_prod;
  assign p_round = {1'b0, prod_q} + (LevelW+SineW+1)'(16384);
  assign p_val   = p_round[LevelW+SineW:15];
  assign imp_sum = $signed(40'(p_val))
                 + {{8{fwd_q[CarryW-1]}}, fwd_q}
                 + {{8{rd_q[CarryW-1]}}, rd_q};
  assign g_prod  = wsine_q * gain_q;

  // fire decision and threshold subtraction
  logic               fired_d;
  logic signed [39:0] imp_sub;
  assign fired_d = ($signed({imp0_q[CarryW-1], imp0_q}) > $signed({9'b0, fire_q}))
                && (sine_q != '0) && (level_q != '0);
  assign imp_sub = {{8{imp0_q[CarryW-1]}}, imp0_q} - $signed(40'(thresh_q));

  // one shared multiply: imp * g; the three weights are 2^18 - 3g, 2g and g
  logic signed [49:0] m_d;
  assign m_d = imp_q * $signed({1'b0, g_q});

  // round to nearest in units of 2^-18 and saturate
  localparam logic signed [55:0] Half = 56'sd131072;
  logic signed [55:0] imp_x, m_x, x_fwd, x_dn, x_dg;
  logic signed [CarryW-1:0] fwd_d, dn_d, diag_d, line_d;
  always_comb begin
    imp_x  = {{6{imp_q[CarryW-1]}}, imp_q, 18'b0};
    m_x    = {{6{m_q[49]}}, m_q};
    x_fwd  = imp_x - m_x - (m_x <<< 1) + Half;
    x_dn   = (m_x <<< 1) + Half;
    x_dg   = m_x + Half;
    fwd_d  = sat32({{2{x_fwd[55]}}, x_fwd[55:18]});
    dn_d   = sat32({{2{x_dn[55]}}, x_dn[55:18]});
    diag_d = sat32({{2{x_dg[55]}}, x_dg[55:18]});
    line_d = sat32({{8{diag_q[CarryW-1]}}, diag_q} + {{8{dn_d[CarryW-1]}}, dn_d});
  end

  // write back completes when the result register is free or being drained
  logic wb_go;
  assign wb_go = (state_q == S_WB) && (!out_valid_q || m_axis_tready);

  // memory write side: sweep zeros or write the new line carry
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = col_q;
    mem_wdata = line_d;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (wb_go) begin
      mem_we = 1'b1;
    end
  end

  // the read is issued at accept and the write lands in write back, so the
  // next pixel's read always sees the stored value: no forwarding needed
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_go) begin
      rd_q <= line_mem[col_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      level_q <= in_level;
      sine_q  <= in_sine;
      prod_q  <= in_sine * in_level;
    end
    if (state_q == S_IMP) begin
      imp0_q <= sat32(imp_sum);
      g_q    <= g_prod[31:15];
    end
    if (state_q == S_FIRE) begin
      fired_q <= fired_d;
      imp_q   <= fired_d ? sat32(imp_sub) : imp0_q;
    end
    if (state_q == S_MUL) begin
      m_q <= m_d;
    end
  end

  // control, counters, carries, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      width_q     <= DimW'(256);
      height_q    <= DimW'(128);
      thresh_q    <= ThrW'(112640);
      fire_q      <= ThrW'(7885);
      gain_q      <= GainW'(32768);
      col_q       <= '0;
      row_q       <= '0;
      max_col_q   <= '0;
      wsine_q     <= '0;
      fwd_q       <= '0;
      diag_q      <= '0;
      clr_cnt_q   <= '0;
      clr_last_q  <= ColW'(MaxWidth - 1);
      out_valid_q <= 1'b0;
      out_fired_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_addr_i))
          RegImageWidth:      width_q  <= cfg_data_i[DimW-1:0];
          RegImageHeight:     height_q <= cfg_data_i[DimW-1:0];
          RegSampleThreshold: thresh_q <= cfg_data_i[ThrW-1:0];
          RegFireLevel:       fire_q   <= cfg_data_i[ThrW-1:0];
          RegSlideGain:       gain_q   <= cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end

      // result taken and no new one arriving this cycle
      if (m_axis_tready && !wb_go) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_go) begin
            wsine_q <= wsine_d;
            if (col_q > max_col_q) max_col_q <= col_q;
            state_q <= S_IMP;
          end
        end
        S_IMP:  state_q <= S_FIRE;
        S_FIRE: state_q <= S_MUL;
        S_MUL:  state_q <= S_WB;
        S_WB: begin
          if (wb_go) begin
            out_valid_q <= 1'b1;
            out_fired_q <= fired_q;
            out_col_q   <= col_q;
            out_row_q   <= row_q;
            out_last_q  <= img_last;
            if (img_last) begin
              // image end: clear carries and sweep the used part of the store
              fwd_q      <= '0;
              diag_q     <= '0;
              col_q      <= '0;
              row_q      <= '0;
              max_col_q  <= '0;
              clr_cnt_q  <= '0;
              clr_last_q <= max_col_q;
              state_q    <= S_CLR;
            end else begin
              fwd_q  <= fwd_d;
              diag_q <= diag_d;
              if (row_end) begin
                row_q <= row_q + RowW'(1);
                col_q <= odd_row ? '0 : ColW'(w_eff - DimW'(1));
              end else begin
                col_q <= odd_row ? (col_q - ColW'(1)) : (col_q + ColW'(1));
              end
              state_q <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          if (clr_cnt_q == clr_last_q) begin
            state_q <= S_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + ColW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ColW - RowW)'(0), out_row_q, out_col_q};
  assign m_axis_tuser  = out_fired_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // no pixel is taken while the line store is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !s_axis_tready)
    else $error("pixel accepted during line store sweep");

  // the last pixel of an image always starts a sweep with carries cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_go && img_last) |=> ((state_q == S_CLR) && (fwd_q == '0) && (diag_q == '0)))
    else $error("image end did not clear carries");

  // a waiting result is never overwritten by write back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && (state_q == S_WB)) |=> (state_q == S_WB))
    else $error("result overwritten before it was taken");

  // a sweep never runs past its last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (clr_cnt_q <= clr_last_q))
    else $error("line store sweep overran");
`endif

endmodule
